// ===== hdl/wtks_pkg.sv =====
`default_nettype none
package wtks_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int DIV_STEPS       = 32;
  localparam int DIV_CNT_W       = $clog2(DIV_STEPS);
  localparam int RANK_W          = 6;

  localparam logic OP_OFFER = 1'b0;
  localparam logic OP_EMIT  = 1'b1;

  localparam logic [1:0] REG_CURRENT_TIME = 2'd0;
  localparam logic [1:0] REG_HTML_TYPE    = 2'd1;
  localparam logic [1:0] REG_TEXT_TYPE    = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [31:0] url_handle;
    logic [31:0] visit_count;
    logic [31:0] last_visit_time;
    logic [7:0]  media_code;
  } in_item_t;

  typedef struct packed {
    logic [31:0]       entry_handle;
    logic [31:0]       entry_weight;
    logic [RANK_W-1:0] rank;
    logic              last_of_run;
    logic              list_empty;
  } result_t;

  typedef struct packed {
    logic [31:0] current_time;
    logic [7:0]  html_type_code;
    logic [7:0]  text_type_code;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic insert;
    logic emit_step;
  } cmd_t;

  typedef struct packed {
    logic cand_ok;
    logic div_last;
    logic emit_last;
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_INSERT,
    ST_EMIT
  } state_t;

endpackage
`default_nettype wire

// ===== hdl/wtks_ctrl.sv =====
`default_nettype none
module wtks_ctrl import wtks_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  input  wire logic    operation,
  input  wire status_t status,
  output logic         busy,
  output cmd_t         cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (operation == OP_EMIT) begin
            state_next = ST_EMIT;
          end else if (status.cand_ok) begin
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (status.div_last) begin
          state_next = ST_INSERT;
        end
      end
      ST_INSERT: state_next = ST_IDLE;
      ST_EMIT: begin
        if (status.emit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b1;
    cmd  = '0;
    unique case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start && (operation == OP_OFFER) && status.cand_ok;
      end
      ST_DIV:    cmd.div_step  = 1'b1;
      ST_INSERT: cmd.insert    = 1'b1;
      ST_EMIT:   cmd.emit_step = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd)) else $error("more than one datapath command at once");

  // insertion always follows the last divider step and ends the item
  a_insert_after_div: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |-> $past(cmd.div_step) && $past(status.div_last))
    else $error("insert without completed division");

  a_insert_ends: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |=> !busy) else $error("still busy after insert");

endmodule
`default_nettype wire

// ===== hdl/wtks_datapath.sv =====
`default_nettype none
module wtks_datapath import wtks_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire in_item_t item,
  input  wire cfg_t     cfg,
  input  wire cmd_t     cmd,
  output status_t       status,
  output result_t       result,
  output logic          result_strobe
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // divider
  logic [31:0]          rem;
  logic [31:0]          quo;
  logic [31:0]          divisor;
  logic [31:0]          cand_handle;
  logic [DIV_CNT_W-1:0] step_cnt;
  logic [32:0]          trial;
  logic [33:0]          diff;
  logic [31:0]          age;

  // kept list, best first
  logic [31:0]          kw [MAX_ENTRIES];
  logic [31:0]          kh [MAX_ENTRIES];
  logic [CNT_W-1:0]     count;
  logic [MAX_ENTRIES-1:0] le;
  logic [RANK_W-1:0]    rank_cnt;
  logic                 empty;
  logic                 last;

  assign age = (cfg.current_time >= item.last_visit_time) ?
               (cfg.current_time - item.last_visit_time) : 32'd0;

  assign trial = {rem, quo[31]};
  assign diff  = {1'b0, trial} - {2'b00, divisor};

  assign status.cand_ok   = (item.visit_count != 32'd0) &&
                            ((item.media_code == cfg.html_type_code) ||
                             (item.media_code == cfg.text_type_code));
  assign status.div_last  = (step_cnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign status.emit_last = (count <= CNT_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem         <= '0;
      quo         <= age;
      divisor     <= item.visit_count;
      cand_handle <= item.url_handle;
    end else if (cmd.div_step) begin
      if (!diff[33]) begin
        rem <= diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= trial[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_cnt <= '0;
    end else if (cmd.load) begin
      step_cnt <= '0;
    end else if (cmd.div_step) begin
      step_cnt <= step_cnt + 1'b1;
    end
  end

  // entries that stay ahead of the new weight (ties keep the older entry first)
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      le[i] = (CNT_W'(i) < count) && (kw[i] <= quo);
    end
  end

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_slot
    always_ff @(posedge clk) begin
      if (cmd.insert && !le[g]) begin
        if (g == 0) begin
          kw[g] <= quo;
          kh[g] <= cand_handle;
        end else if (le[(g == 0) ? 0 : g-1]) begin
          kw[g] <= quo;
          kh[g] <= cand_handle;
        end else begin
          kw[g] <= kw[(g == 0) ? 0 : g-1];
          kh[g] <= kh[(g == 0) ? 0 : g-1];
        end
      end else if (cmd.emit_step && (g < MAX_ENTRIES - 1)) begin
        kw[g] <= kw[(g < MAX_ENTRIES - 1) ? g+1 : g];
        kh[g] <= kh[(g < MAX_ENTRIES - 1) ? g+1 : g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.insert) begin
      if (count != CNT_W'(MAX_ENTRIES)) begin
        count <= count + 1'b1;
      end
    end else if (cmd.emit_step) begin
      if (count != '0) begin
        count <= count - 1'b1;
      end
    end
  end

  assign empty = (count == '0);
  assign last  = status.emit_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_cnt <= '0;
    end else if (cmd.emit_step) begin
      rank_cnt <= last ? '0 : rank_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      result.entry_handle <= empty ? 32'd0 : kh[0];
      result.entry_weight <= empty ? 32'd0 : kw[0];
      result.rank         <= empty ? '0 : rank_cnt;
      result.last_of_run  <= last;
      result.list_empty   <= empty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.emit_step;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_ENTRIES)) else $error("kept count beyond list size");

  a_insert_fills: assert property (@(posedge clk) disable iff (rst)
    cmd.insert |=> count != '0) else $error("list empty after insert");

  a_empty_alone: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.list_empty |-> result.last_of_run && result.rank == '0)
    else $error("empty result not a single last item");

endmodule
`default_nettype wire

// ===== hdl/weighted_top_k_selector_top.sv =====
// Offer: a rejected item leaves the block idle; a taken one runs a load, 32 steps of the
// bit-serial restoring divider and one insert into the shift-register list.
// Emit: busy for one emit step per kept entry, or one step when the list is empty;
// results follow on consecutive cycles, each registered from an emit step.
// Results cannot be stalled. Synchronous reset empties the list and restores
// the register defaults (html type 0, text type 1, time 0).
`default_nettype none
module weighted_top_k_selector_top import wtks_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire in_item_t   item,
  output result_t         result,
  output logic            result_strobe,
  input  wire logic       psel,
  input  wire logic       penable,
  input  wire logic       pwrite,
  input  wire logic [3:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;
  logic    wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.current_time   <= 32'd0;
      cfg.html_type_code <= 8'd0;
      cfg.text_type_code <= 8'd1;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_CURRENT_TIME: cfg.current_time   <= pwdata;
        REG_HTML_TYPE:    cfg.html_type_code <= pwdata[7:0];
        REG_TEXT_TYPE:    cfg.text_type_code <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_CURRENT_TIME: prdata = cfg.current_time;
      REG_HTML_TYPE:    prdata = {24'd0, cfg.html_type_code};
      REG_TEXT_TYPE:    prdata = {24'd0, cfg.text_type_code};
      default:          prdata = 32'd0;
    endcase
  end

  wtks_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (item.operation),
    .status    (status),
    .busy      (busy),
    .cmd       (cmd)
  );

  wtks_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .item          (item),
    .cfg           (cfg),
    .cmd           (cmd),
    .status        (status),
    .result        (result),
    .result_strobe (result_strobe)
  );

endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
  import wtks_pkg::*;

  localparam int DEPTH     = MAX_ENTRIES_DEF;
  localparam int SETTLE    = 40;    // covers the busy span of a taken offer (divide, then insert)
  localparam int QUIET_MAX = 2000;

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        start   = 1'b0;
  logic        busy;
  in_item_t    item    = '0;
  result_t     result;
  logic        result_strobe;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b1;
  logic [3:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  // shadow of the block: registers and the kept list, best first
  logic [31:0] cur_time  = 32'd0;
  logic [7:0]  html_code = 8'd0;
  logic [7:0]  text_code = 8'd1;
  logic [31:0] kept_handle [DEPTH];
  logic [31:0] kept_weight [DEPTH];
  int          kept_n    = 0;
  result_t     ranked_out [$];

  int errors     = 0;
  int n_taken    = 0;
  int n_results  = 0;
  int n_phases   = 0;
  int n_displace = 0;
  int max_emit   = 0;
  int quiet      = 0;
  bit gaps_on    = 1'b0;

  weighted_top_k_selector_top #(.MAX_ENTRIES(DEPTH)) uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .item(item),
    .result(result), .result_strobe(result_strobe),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // apply one accepted item to the shadow list, queueing any list entries it emits
  task automatic select_step(input in_item_t it);
    logic [31:0] age, wgt;
    int pos, i;
    result_t r;
    if (it.operation == OP_OFFER) begin
      if (it.visit_count == 32'd0) return;
      if (it.media_code != html_code && it.media_code != text_code) return;
      age = (cur_time >= it.last_visit_time) ? cur_time - it.last_visit_time : 32'd0;
      wgt = age / it.visit_count;
      pos = 0;
      while (pos < kept_n && kept_weight[pos] <= wgt) pos++;
      if (kept_n >= DEPTH) begin
        if (pos >= DEPTH) return;
        i = DEPTH - 1;
        n_displace++;
      end else begin
        i = kept_n;
        kept_n++;
      end
      while (i > pos) begin
        kept_handle[i] = kept_handle[i-1];
        kept_weight[i] = kept_weight[i-1];
        i--;
      end
      kept_handle[pos] = it.url_handle;
      kept_weight[pos] = wgt;
    end else begin
      if (kept_n == 0) begin
        r = '0;
        r.last_of_run = 1'b1;
        r.list_empty  = 1'b1;
        ranked_out.push_back(r);
      end else begin
        for (i = 0; i < kept_n; i++) begin
          r.entry_handle = kept_handle[i];
          r.entry_weight = kept_weight[i];
          r.rank         = RANK_W'(i);
          r.last_of_run  = (i == kept_n - 1);
          r.list_empty   = 1'b0;
          ranked_out.push_back(r);
        end
      end
      if (kept_n > max_emit) max_emit = kept_n;
      kept_n = 0;
    end
  endtask

  task automatic idle_gap(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // start is left high on return (unless a random idle gap was taken) so the next item can follow without a gap
  task automatic send_item(input in_item_t it);
    item  <= it;
    start <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    select_step(it);
    n_taken++;
    if (gaps_on && $urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 9));
  endtask

  // hold off until every list entry has come out and any offer has finished
  task automatic wait_idle();
    start <= 1'b0;
    while (ranked_out.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      REG_CURRENT_TIME: cur_time  = val;
      REG_HTML_TYPE:    html_code = val[7:0];
      REG_TEXT_TYPE:    text_code = val[7:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(input logic [31:0] t, input logic [7:0] h, input logic [7:0] x);
    wait_idle();
    write_reg(REG_CURRENT_TIME, t);
    write_reg(REG_HTML_TYPE, {24'd0, h});
    write_reg(REG_TEXT_TYPE, {24'd0, x});
  endtask

  function automatic in_item_t mk_offer(input logic [31:0] h, input logic [31:0] v,
                                        input logic [31:0] l, input logic [7:0] c);
    in_item_t it;
    it.operation       = OP_OFFER;
    it.url_handle      = h;
    it.visit_count     = v;
    it.last_visit_time = l;
    it.media_code      = c;
    return it;
  endfunction

  function automatic in_item_t rand_emit();
    in_item_t it;
    it.operation       = OP_EMIT;
    it.url_handle      = $urandom;
    it.visit_count     = $urandom;
    it.last_visit_time = $urandom;
    it.media_code      = 8'($urandom);
    return it;
  endfunction

  // mostly accepted candidates with clustered weights, so ties and overflow are common
  function automatic in_item_t rand_offer();
    in_item_t it;
    it = mk_offer($urandom, $urandom_range(1, 4), cur_time - $urandom_range(0, 40),
                  $urandom_range(0, 1) ? html_code : text_code);
    case ($urandom_range(0, 9))
      0: it.visit_count     = $urandom;
      1: it.last_visit_time = $urandom;
      2: it.visit_count     = 32'd0;
      3: it.media_code      = 8'($urandom);
      default: ;
    endcase
    return it;
  endfunction

  task automatic test_empty_emit();
    send_item(rand_emit());
    send_item(rand_emit());
  endtask

  // reset codes: html 0, text 1, time 0 so every age saturates to zero
  task automatic test_reset_codes();
    send_item(mk_offer(32'd1, 32'd5, 32'd0, 8'd0));
    send_item(mk_offer(32'd2, 32'd1, 32'hFFFF_FFFF, 8'd1));
    send_item(mk_offer(32'd3, 32'd0, 32'd0, 8'd0));
    send_item(mk_offer(32'd4, 32'd3, 32'd0, 8'd2));
    send_item(rand_emit());
  endtask

  task automatic test_extremes();
    set_regs(32'hFFFF_FFFF, 8'hFF, 8'h80);
    send_item(mk_offer(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 8'hFF));
    send_item(mk_offer(32'd0, 32'd1, 32'd0, 8'h80));
    send_item(mk_offer(32'hA5A5_A5A5, 32'd7, 32'hFFFF_FFFF, 8'hFF));
    send_item(mk_offer(32'h5A5A_5A5A, 32'd2, 32'd1, 8'h80));
    send_item(mk_offer(32'd6, 32'd1, 32'd0, 8'h00));
    send_item(rand_emit());
  endtask

  // last visit after the scan time, both codes equal, pause with results pending
  task automatic test_future_visits();
    set_regs(32'd100, 8'h7F, 8'h7F);
    send_item(mk_offer(32'h0000_0011, 32'd9, 32'd200, 8'h7F));
    send_item(mk_offer(32'h0000_0022, 32'd1, 32'd100, 8'h7F));
    send_item(rand_emit());
    wait_idle();
    send_item(mk_offer(32'h0000_0033, 32'd3, 32'd10, 8'h7F));
    send_item(rand_emit());
  endtask

  task automatic random_regs();
    logic [31:0] t;
    logic [7:0] h, x;
    int mask;
    case ($urandom_range(0, 5))
      0: t = 32'd0;
      1: t = 32'hFFFF_FFFF;
      2: t = $urandom_range(0, 60);
      default: t = $urandom;
    endcase
    h = 8'($urandom);
    x = ($urandom_range(0, 3) == 0) ? h : 8'($urandom);
    if ($urandom_range(0, 7) == 0) begin
      h = 8'h00;
      x = 8'hFF;
    end
    mask = $urandom_range(1, 7);
    if (mask[0]) write_reg(REG_CURRENT_TIME, t);
    if (mask[1]) write_reg(REG_HTML_TYPE, {24'd0, h});
    if (mask[2]) write_reg(REG_TEXT_TYPE, {24'd0, x});
  endtask

  task automatic test_random_traffic(input int quota, input bit with_gaps);
    int useful, batch, k;
    in_item_t it;
    useful = 0;
    while (useful < quota) begin
      wait_idle();
      random_regs();
      n_phases++;
      gaps_on = with_gaps && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0:       batch = $urandom_range(0, 4);
        1, 2:    batch = $urandom_range(5, 16);
        default: batch = $urandom_range(17, 40);
      endcase
      for (k = 0; k < batch; k++) begin
        it = rand_offer();
        if (it.visit_count != 0 &&
            (it.media_code == html_code || it.media_code == text_code)) useful++;
        send_item(it);
        if (with_gaps && $urandom_range(0, 31) == 0) wait_idle();
      end
      send_item(rand_emit());
      useful++;
      if ($urandom_range(0, 7) == 0) begin
        send_item(rand_emit());
        useful++;
      end
    end
    gaps_on = 1'b0;
  endtask

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_strobe === 1'b1) begin
      n_results++;
      if (ranked_out.size() == 0) begin
        $error("result with none due: entry_handle %h entry_weight %h",
               result.entry_handle, result.entry_weight);
        errors++;
      end else begin
        want = ranked_out.pop_front();
        if (result.entry_handle !== want.entry_handle) begin
          $error("entry_handle: expected %h, got %h", want.entry_handle, result.entry_handle);
          errors++;
        end
        if (result.entry_weight !== want.entry_weight) begin
          $error("entry_weight: expected %h, got %h", want.entry_weight, result.entry_weight);
          errors++;
        end
        if (result.rank !== want.rank) begin
          $error("rank: expected %0d, got %0d", want.rank, result.rank);
          errors++;
        end
        if (result.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %b, got %b", want.last_of_run, result.last_of_run);
          errors++;
        end
        if (result.list_empty !== want.list_empty) begin
          $error("list_empty: expected %b, got %b", want.list_empty, result.list_empty);
          errors++;
        end
      end
    end
  end

  // cycles with no item, no result and no register write
  always @(posedge clk) begin
    if (rst || (start && busy === 1'b0) || result_strobe === 1'b1 ||
        (psel && penable && pwrite && pready === 1'b1)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_MAX) begin
      $display("weighted_top_k_selector_top test failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    test_empty_emit();
    test_reset_codes();
    test_extremes();
    test_future_visits();
    test_random_traffic(300, 1'b1);
    test_random_traffic(30, 1'b0);
    wait_idle();
    if (ranked_out.size() != 0) begin
      $error("%0d list entries never came out", ranked_out.size());
      errors++;
    end
    $display("%0d items taken over %0d register settings, %0d list entries checked",
             n_taken, n_phases, n_results);
    $display("%0d full-list displacements, longest emit %0d entries", n_displace, max_emit);
    if (errors == 0) begin
      $display("weighted_top_k_selector_top test passed");
    end else begin
      $display("weighted_top_k_selector_top test failed");
    end
    $finish;
  end

endmodule
